// ===== rtl/fixed_block_pool_allocator_unit_defines.svh =====
// assertion macros used by the pool allocator top level
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define FBPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fbpa property violated");
// condition must never be seen outside reset
`define FBPA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fbpa forbidden condition seen");
`else
`define FBPA_ASSERT(lbl, clk, rstn, prop)
`define FBPA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/fbpa_pkg.sv =====
// types, constants and helpers of the fixed block pool allocator
package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 32;
  localparam int BSIZE_W    = 17;
  localparam int NUM_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = IDX_W + BSIZE_W;

  localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = IDX_W + ADDR_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM   = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(64);
  localparam logic [NUM_W-1:0]   NUM_RST   = NUM_W'(256);

  // free list link: block index or end of list
  typedef struct packed {
    logic             is_end;
    logic [IDX_W-1:0] idx;
  } link_t;

  localparam link_t LINK_END = '{is_end: 1'b1, idx: '0};

  // request to the link store
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clear;
    logic [IDX_W-1:0] addr;
    link_t            wr_link;
  } link_req_t;

  // one result item
  typedef struct packed {
    logic [CNT_W-1:0]    free_count;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [IDX_W-1:0]    granted_index;
  } result_t;

  // clamp the written block count into 1..MAX_BLOCKS
  function automatic logic [CNT_W-1:0] clamp_count(input logic [NUM_W-1:0] num);
    logic [CNT_W-1:0] n;
    if (num == '0) begin
      n = CNT_W'(1);
    end else if (32'(num) > 32'(MAX_BLOCKS)) begin
      n = CNT_W'(MAX_BLOCKS);
    end else begin
      n = CNT_W'(num);
    end
    return n;
  endfunction

endpackage

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// top level of the fixed block pool allocator: control, registers and stream ports
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata block_index, tuser op
//  m_axis    out        m_axis_tvalid/tready      tdata index/address/count, tuser status
//  cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// a release, an exhausted acquire or a rejected release completes from ST_IDLE;
// a granted acquire also passes through ST_READ for the registered read of the head's link.
// reset clears all link valid bits at once, so no clearing pass is needed;
// a num_blocks write relinks the chain the same way.
// one result waits in the output register while the next request is taken;
// a second finished result is held internally until the output frees up.
`include "fixed_block_pool_allocator_unit_defines.svh"
module fixed_block_pool_allocator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] block_index
  input  logic                             s_axis_tuser,  // [0] op
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] granted_index, [39:8] granted_address, [48:40] free_count, rest zero
  output logic [fbpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [fbpa_pkg::STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [CNT_W-1:0]   n_q;
  link_t              head_q, head_d;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [IDX_W-1:0]   gidx_q;
  logic [ADDR_W-1:0]  gaddr_q;
  result_t            res_q, res_d, out_q;
  logic               out_vld_q;

  link_req_t          link_req;
  link_t              rd_link;
  logic               req_acc;
  logic               cfg_acc;
  logic               emit;
  logic               slot_free;
  logic               load_out;
  logic [IDX_W-1:0]   rel_idx;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  head_addr;

  assign slot_free     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign rel_idx       = s_axis_tdata[IDX_W-1:0];

  // block address of the current head
  assign prod      = PROD_W'(head_q.idx) * PROD_W'(bsize_q);
  assign head_addr = base_q + ADDR_W'(prod);

  // request decode, list update and result build
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    free_cnt_d = free_cnt_q;
    res_d      = '0;
    emit       = 1'b0;
    link_req   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (s_axis_tuser == OP_ACQUIRE) begin
            if (head_q.is_end) begin
              res_d.status     = ST_EXHAUSTED;
              res_d.free_count = free_cnt_q;
              emit             = 1'b1;
            end else begin
              link_req.rd_en = 1'b1;
              link_req.addr  = head_q.idx;
              state_d        = ST_READ;
            end
          end else begin
            if (CNT_W'(rel_idx) >= n_q) begin
              res_d.status     = ST_RANGE;
              res_d.free_count = free_cnt_q;
              emit             = 1'b1;
            end else begin
              link_req.wr_en   = 1'b1;
              link_req.addr    = rel_idx;
              link_req.wr_link = head_q;
              head_d           = '{is_end: 1'b0, idx: rel_idx};
              if (free_cnt_q < n_q) begin
                free_cnt_d = free_cnt_q + CNT_W'(1);
              end
              res_d.status     = ST_OK;
              res_d.free_count = free_cnt_d;
              emit             = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        // popped head's link arrives from the store
        head_d = rd_link;
        if (free_cnt_q != '0) begin
          free_cnt_d = free_cnt_q - CNT_W'(1);
        end
        res_d.granted_index   = gidx_q;
        res_d.granted_address = gaddr_q;
        res_d.status          = ST_OK;
        res_d.free_count      = free_cnt_d;
        emit                  = 1'b1;
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // finished result goes out now or waits in the hold register
    if (emit) begin
      state_d = slot_free ? ST_IDLE : ST_HOLD;
    end

    // relink on a block count write
    if (cfg_acc && cfg_index_i == REG_NUM) begin
      link_req.clear = 1'b1;
      head_d         = '{is_end: 1'b0, idx: '0};
      free_cnt_d     = clamp_count(cfg_data_i[NUM_W-1:0]);
    end
  end

  assign load_out = (emit || state_q == ST_HOLD) && slot_free;

  // state, list head, free count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '{is_end: 1'b0, idx: '0};
      free_cnt_q <= clamp_count(NUM_RST);
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      free_cnt_q <= free_cnt_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      bsize_q <= BSIZE_RST;
      n_q     <= clamp_count(NUM_RST);
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_BASE:  base_q  <= cfg_data_i[ADDR_W-1:0];
        REG_BSIZE: bsize_q <= cfg_data_i[BSIZE_W-1:0];
        REG_NUM:   n_q     <= clamp_count(cfg_data_i[NUM_W-1:0]);
        default:   ;
      endcase
    end
  end

  // grant payload, held result and output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      gidx_q  <= head_q.idx;
      gaddr_q <= head_addr;
    end
    if (emit && !slot_free) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_q <= (state_q == ST_HOLD) ? res_q : res_d;
    end
  end

  fbpa_link_store u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (link_req),
    .count_i   (n_q),
    .rd_link_o (rd_link)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.free_count, out_q.granted_address,
                                       out_q.granted_index});
  assign m_axis_tuser  = out_q.status;

  // free count never exceeds the block count
  `FBPA_ASSERT_NEVER(a_cnt_le_n, clk_i, rst_ni, free_cnt_q > n_q)
  // an empty list implies no free blocks counted
  `FBPA_ASSERT(a_end_empty, clk_i, rst_ni, head_q.is_end |-> free_cnt_q == '0)
  // the link read state is left straight away, never held
  `FBPA_ASSERT(a_read_one, clk_i, rst_ni, state_q == ST_READ |=> state_q != ST_READ)

endmodule

// ===== rtl/fbpa_link_store.sv =====
// link store: synchronous memory of next-free links with valid bits, read through a register
module fbpa_link_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fbpa_pkg::link_req_t        req_i,
  input  logic [fbpa_pkg::CNT_W-1:0] count_i,
  output fbpa_pkg::link_t            rd_link_o
);
  import fbpa_pkg::*;

  link_t                 mem_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld_q;
  link_t                 rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic [CNT_W-1:0]      next_idx;
  link_t                 chain_link;

  // memory array, written and read at one address a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_link;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
      rd_addr_q <= req_i.addr;
    end
  end

  // per-entry valid bits; an entry never written since relink holds the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  // chain value for an unwritten entry: next index, end mark at the last block
  assign next_idx = CNT_W'(rd_addr_q) + CNT_W'(1);

  always_comb begin
    if (next_idx < count_i) begin
      chain_link = '{is_end: 1'b0, idx: next_idx[IDX_W-1:0]};
    end else begin
      chain_link = LINK_END;
    end
  end

  assign rd_link_o = rd_vld_q ? rd_data_q : chain_link;

endmodule

// ===== dv/tb_fixed_block_pool_allocator_unit.sv =====
// self-checking stream testbench of the fixed block pool allocator with a free-list shadow model
module tb_fixed_block_pool_allocator_unit;
  import fbpa_pkg::*;

  // free-list link value that ends the chain
  localparam logic [8:0] CHAIN_END = 9'h100;
  // register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // cycles without any handshake before the run is abandoned
  localparam int IDLE_LIMIT = 2000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       op;
    logic [7:0] idx;
  } pool_req_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] address;
    logic [1:0]  status;
    logic [8:0]  count;
  } pool_grant_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  pool_req_t   request_q[$];
  pool_grant_t grant_q[$];

  // shadow pool state and registers
  logic [8:0]  chain[256];
  logic [8:0]  head_blk;
  logic [8:0]  free_cnt;
  logic [31:0] cfg_base;
  logic [16:0] cfg_bsize;
  logic [8:0]  cfg_num;

  // traffic shaping, set between phases
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  int mismatches = 0;
  int n_reqs = 0, n_grants = 0, n_exhausted = 0, n_rejects = 0, n_writes = 0;
  int idle_cycles = 0;

  fixed_block_pool_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // block count in use, clamped to 1..256
  function automatic logic [8:0] pool_size();
    if (cfg_num == 9'd0) begin
      return 9'd1;
    end else if (cfg_num > 9'd256) begin
      return 9'd256;
    end
    return cfg_num;
  endfunction

  // rebuild the chain 0,1,...,n-1,end
  function automatic void relink_pool();
    logic [8:0] n;
    n = pool_size();
    for (int i = 0; i < 256; i++) begin
      chain[i] = (i + 1 < n) ? 9'(i + 1) : CHAIN_END;
    end
    head_blk = 9'd0;
    free_cnt = n;
  endfunction

  // apply one request to the shadow pool and return the result it yields
  function automatic pool_grant_t pool_outcome(pool_req_t r);
    pool_grant_t g;
    logic [8:0]  n;
    logic [63:0] addr;
    g = '0;
    n = pool_size();
    n_reqs++;
    if (r.op == OP_ACQUIRE) begin
      if (head_blk[8]) begin
        g.status = ST_EXHAUSTED;
        n_exhausted++;
      end else begin
        g.index = head_blk[7:0];
        addr = 64'(cfg_base) + 64'(head_blk[7:0]) * 64'(cfg_bsize);
        g.address = addr[31:0];
        head_blk = chain[head_blk[7:0]];
        if (free_cnt != 9'd0) free_cnt--;
        n_grants++;
      end
    end else if (9'(r.idx) >= n) begin
      g.status = ST_RANGE;
      n_rejects++;
    end else begin
      chain[r.idx] = head_blk;
      head_blk = {1'b0, r.idx};
      if (free_cnt < n) free_cnt++;
    end
    g.count = free_cnt;
    return g;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    logic go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        grant_q.push_back(pool_outcome(request_q.pop_front()));
      end
      go = request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct;
      if (go) begin
        s_axis_tdata <= request_q[0].idx;
        s_axis_tuser <= request_q[0].op;
      end
      s_axis_tvalid <= go;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result monitor and receiver back-pressure
  always @(posedge clk_i) begin
    pool_grant_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got tdata %0h tuser %0h",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          check_field("granted_index", 32'(want.index), 32'(m_axis_tdata[7:0]));
          check_field("granted_address", want.address, m_axis_tdata[39:8]);
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("free_count", 32'(want.count), 32'(m_axis_tdata[48:40]));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= rx_stall_pct;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one register write, mirrored into the shadow registers on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BASE:  cfg_base = data;
      REG_BSIZE: cfg_bsize = data[16:0];
      REG_NUM: begin
        cfg_num = data[8:0];
        relink_pool();
      end
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || grant_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_req(input logic op, input logic [7:0] idx);
    pool_req_t r;
    r.op  = op;
    r.idx = idx;
    request_q.push_back(r);
  endtask

  // random register settings, extremes weighted in, junk in unused data bits
  task automatic program_pool();
    logic [16:0] bs;
    logic [8:0]  num;
    case ($urandom_range(0, 5))
      0:       bs = 17'd0;
      1:       bs = 17'h10000;
      2:       bs = 17'h1FFFF;
      3:       bs = 17'd1;
      default: bs = 17'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 7))
      0:       num = 9'd0;
      1:       num = 9'h1FF;
      2:       num = 9'd256;
      3:       num = 9'($urandom_range(200, 300));
      default: num = 9'($urandom_range(1, 12));
    endcase
    write_reg(REG_BASE, $urandom);
    write_reg(REG_BSIZE, {15'($urandom), bs});
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    write_reg(REG_NUM, {23'($urandom), num});
  endtask

  // alternating acquire-heavy and release-heavy bursts so the pool drains and refills
  task automatic random_phase(input int items, input int tx_pct, input int rx_pct,
                              input logic squeeze);
    int         burst;
    logic       acq_bias;
    logic [8:0] n;
    pool_req_t  r;
    burst = 0;
    acq_bias = 1'b0;
    program_pool();
    n = pool_size();
    @(posedge clk_i);
    tx_idle_pct  <= tx_pct;
    rx_stall_pct <= rx_pct;
    if (squeeze) hold_go <= 1'b1;
    for (int k = 0; k < items; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(2, 12);
        acq_bias = !acq_bias;
      end
      burst--;
      r.op = (($urandom_range(0, 99) < 80) == acq_bias) ? OP_ACQUIRE : OP_RELEASE;
      if (r.op == OP_RELEASE && $urandom_range(0, 9) < 8) begin
        r.idx = 8'($urandom_range(0, n - 1));
      end else begin
        r.idx = 8'($urandom);
      end
      request_q.push_back(r);
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    cfg_base  = BASE_RST;
    cfg_bsize = BSIZE_RST;
    cfg_num   = NUM_RST;
    relink_pool();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: grants, full-pool release saturation, top index
    push_req(OP_ACQUIRE, 8'hFF);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_RELEASE, 8'd255);
    push_req(OP_RELEASE, 8'd1);
    push_req(OP_RELEASE, 8'd0);
    push_req(OP_ACQUIRE, 8'h5A);
    wait_drained();

    // three blocks, address wrap, exhaustion, out-of-range releases
    write_reg(REG_BASE, 32'hFFFF_FFF0);
    write_reg(REG_BSIZE, 32'hFFFF_FFFF);
    write_reg(REG_NUM, 32'd3);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_ACQUIRE, 8'hFF);
    push_req(OP_RELEASE, 8'd3);
    push_req(OP_RELEASE, 8'd255);
    push_req(OP_RELEASE, 8'd2);
    push_req(OP_ACQUIRE, 8'h00);
    wait_drained();

    // zero count clamps to one block, zero block size, double release
    write_reg(REG_NUM, 32'd0);
    write_reg(REG_BSIZE, 32'd0);
    write_reg(REG_BASE, 32'h1234_5678);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_RELEASE, 8'd1);
    push_req(OP_RELEASE, 8'd0);
    push_req(OP_RELEASE, 8'd0);
    wait_drained();

    // oversized count clamps to 256, block size 0x10000 at top of address space
    write_reg(REG_NUM, 32'h1FF);
    write_reg(REG_BSIZE, 32'h0001_0000);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_ACQUIRE, 8'h00);
    push_req(OP_RELEASE, 8'd128);
    wait_drained();

    // random traffic under the idling mixes, then the long receiver hold-off
    random_phase(110, 0, 0, 1'b0);
    random_phase(110, 70, 0, 1'b0);
    random_phase(110, 0, 70, 1'b0);
    random_phase(90, 12, 12, 1'b0);
    random_phase(30, 0, 0, 1'b1);

    $display("covered %0d requests: %0d grants, %0d exhausted acquires, %0d rejected releases",
             n_reqs, n_grants, n_exhausted, n_rejects);
    $display("with %0d register writes across idle, stall and hold-off phases", n_writes);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_link_store.sv
rtl/fixed_block_pool_allocator_unit.sv
dv/tb_fixed_block_pool_allocator_unit.sv
